// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/lkci_pkg.sv =====
`default_nettype none

package lkci_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_FRAC,
        S_WEIGHT,
        S_BLEND,
        S_DONE
    } state_t;

    localparam logic [2:0] CFG_LOOP_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_KEY_TIMES    = 3'd1;
    localparam logic [2:0] CFG_KEY_COLOUR_0 = 3'd2;
    localparam logic [2:0] CFG_KEY_COLOUR_1 = 3'd3;
    localparam logic [2:0] CFG_KEY_COLOUR_2 = 3'd4;
    localparam logic [2:0] CFG_KEY_COLOUR_3 = 3'd5;

    localparam logic [63:0] KEY_TIMES_RESET = 64'h8000_8000_8000_8000;
    localparam logic [31:0] COLOUR_WHITE    = 32'hFFFF_FFFF;

    localparam logic [5:0] DIV_STEPS_MOD  = 6'd33;
    localparam logic [5:0] DIV_STEPS_FRAC = 6'd15;

    typedef struct packed {
        logic        start;
        logic [31:0] rem_init;
        logic [32:0] dividend;
        logic [31:0] divisor;
        logic [5:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/looping_keyframe_colour_interpolator.sv =====
// A 33-step remainder and two 15-step quotients run in turn on one shared restoring divider,
// then the four channels are blended in turn. A zero period skips the divider, no time passed
// yet stops after the remainder, and a colour with no blend is set after the first quotient.
// A new input beat is taken only once the last result is loaded, even while that result waits.
// Reset (aresetn, synchronous, active low) clears the phase, the started flag and the output
// valid, sets the colour and all key colours to white and every key time to one.
`default_nettype none
`include "assert_macros.svh"

module looping_keyframe_colour_interpolator
    import lkci_pkg::*;
#(
    parameter int KEY_STAGES = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // time_delta
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // red, green, blue, alpha
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam logic [1:0] LAST_KEY = 2'(KEY_STAGES - 1);

    logic [31:0] period_reg;
    logic [63:0] key_times_reg;
    logic [31:0] key_col0_reg, key_col1_reg, key_col2_reg, key_col3_reg;

    state_t      state_reg, state_next;
    logic [31:0] phase_reg, phase_next;
    logic        started_reg, started_next;
    logic [31:0] colour_reg, colour_next;
    logic [1:0]  seg_reg, seg_next;
    logic [15:0] u_reg, u_next;
    logic [1:0]  ch_reg, ch_next;
    logic [31:0] out_data_reg, out_data_next;
    logic        m_tvalid_reg, m_tvalid_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [15:0] t_frac;
    logic        seg_found;
    logic [1:0]  seg_hit;
    logic [15:0] key_lo, key_hi;
    logic [31:0] from_col, to_col;
    logic [7:0]  chan_a, chan_b;
    logic signed [8:0]  chan_d;
    logic signed [25:0] prod;
    logic signed [25:0] acc;
    logic [32:0] sum;

    function automatic logic [31:0] col_at(input logic [1:0] idx, input logic [31:0] c0,
                                           input logic [31:0] c1, input logic [31:0] c2,
                                           input logic [31:0] c3);
        logic [31:0] c;
        case (idx)
            2'd0: begin
                c = c0;
            end
            2'd1: begin
                c = c1;
            end
            2'd2: begin
                c = c2;
            end
            default: begin
                c = c3;
            end
        endcase
        return c;
    endfunction

    lkci_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= '0;
            key_times_reg <= KEY_TIMES_RESET;
            key_col0_reg  <= COLOUR_WHITE;
            key_col1_reg  <= COLOUR_WHITE;
            key_col2_reg  <= COLOUR_WHITE;
            key_col3_reg  <= COLOUR_WHITE;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LOOP_PERIOD: begin
                    period_reg <= cfg_data[31:0];
                end
                CFG_KEY_TIMES: begin
                    key_times_reg <= cfg_data;
                end
                CFG_KEY_COLOUR_0: begin
                    key_col0_reg <= cfg_data[31:0];
                end
                CFG_KEY_COLOUR_1: begin
                    key_col1_reg <= cfg_data[31:0];
                end
                CFG_KEY_COLOUR_2: begin
                    key_col2_reg <= cfg_data[31:0];
                end
                CFG_KEY_COLOUR_3: begin
                    key_col3_reg <= cfg_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign t_frac = {1'b0, div_rsp.quot[14:0]};
    assign sum    = {1'b0, phase_reg} + {1'b0, s_tdata};

    always_comb begin
        seg_found = 1'b0;
        seg_hit   = '0;
        key_lo    = '0;
        key_hi    = '0;
        for (int i = 0; i < KEY_STAGES - 1; i++) begin
            if (!seg_found && t_frac >= key_times_reg[16*i +: 16]
                    && t_frac < key_times_reg[16*(i+1) +: 16]) begin
                seg_found = 1'b1;
                seg_hit   = 2'(i);
                key_lo    = key_times_reg[16*i +: 16];
                key_hi    = key_times_reg[16*(i+1) +: 16];
            end
        end
    end

    assign from_col = col_at(seg_reg, key_col0_reg, key_col1_reg, key_col2_reg, key_col3_reg);
    assign to_col   = col_at(seg_reg + 2'd1, key_col0_reg, key_col1_reg, key_col2_reg,
                             key_col3_reg);
    assign chan_a   = from_col[8*ch_reg +: 8];
    assign chan_b   = to_col[8*ch_reg +: 8];
    assign chan_d   = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
    assign prod     = chan_d * $signed({1'b0, u_reg});
    assign acc      = $signed({3'b000, chan_a, 15'd0}) + prod + 26'sd16384;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        started_next  = started_reg;
        colour_next   = colour_reg;
        seg_next      = seg_reg;
        u_next        = u_reg;
        ch_next       = ch_reg;
        out_data_next = out_data_reg;
        m_tvalid_next = m_tvalid_reg;
        div_req       = '0;
        s_tready      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tdata != '0) begin
                        started_next = 1'b1;
                    end
                    if (period_reg != '0) begin
                        div_req.start    = 1'b1;
                        div_req.rem_init = '0;
                        div_req.dividend = sum;
                        div_req.divisor  = period_reg;
                        div_req.steps    = DIV_STEPS_MOD;
                        state_next       = S_MOD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MOD: begin
                if (div_rsp.done) begin
                    phase_next = div_rsp.rem;
                    if (started_reg) begin
                        div_req.start    = 1'b1;
                        div_req.rem_init = div_rsp.rem;
                        div_req.dividend = '0;
                        div_req.divisor  = period_reg;
                        div_req.steps    = DIV_STEPS_FRAC;
                        state_next       = S_FRAC;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FRAC: begin
                if (div_rsp.done) begin
                    if (t_frac <= key_times_reg[15:0]) begin
                        colour_next = key_col0_reg;
                        state_next  = S_DONE;
                    end else if (t_frac >= key_times_reg[16*(KEY_STAGES-1) +: 16]) begin
                        colour_next = col_at(LAST_KEY, key_col0_reg, key_col1_reg,
                                             key_col2_reg, key_col3_reg);
                        state_next  = S_DONE;
                    end else if (seg_found) begin
                        seg_next         = seg_hit;
                        div_req.start    = 1'b1;
                        div_req.rem_init = {16'd0, t_frac - key_lo};
                        div_req.dividend = '0;
                        div_req.divisor  = {16'd0, key_hi - key_lo};
                        div_req.steps    = DIV_STEPS_FRAC;
                        state_next       = S_WEIGHT;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WEIGHT: begin
                if (div_rsp.done) begin
                    u_next     = div_rsp.quot[15:0];
                    ch_next    = '0;
                    state_next = S_BLEND;
                end
            end
            S_BLEND: begin
                colour_next[8*ch_reg +: 8] = acc[22:15];
                ch_next = ch_reg + 2'd1;
                if (ch_reg == 2'd3) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_data_next = {colour_reg[7:0], colour_reg[15:8],
                                     colour_reg[23:16], colour_reg[31:24]};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= '0;
            started_reg  <= 1'b0;
            colour_reg   <= COLOUR_WHITE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            started_reg  <= started_next;
            colour_reg   <= colour_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        seg_reg      <= seg_next;
        u_reg        <= u_next;
        ch_reg       <= ch_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPLIES(a_div_done_when_waiting, aclk, aresetn, div_rsp.done,
        state_reg == S_MOD || state_reg == S_FRAC || state_reg == S_WEIGHT)
    `ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        state_reg == S_DONE && (!m_tvalid || m_tready), m_tvalid && state_reg == S_IDLE)

endmodule

`default_nettype wire

// ===== rtl/lkci_div.sv =====
`default_nettype none

module lkci_div
    import lkci_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] num_reg, num_next;
    logic [31:0] div_reg, div_next;

    logic [32:0] trial;
    logic [33:0] diff;
    logic        ge;

    assign trial = {rem_reg, num_reg[32]};
    assign diff  = {1'b0, trial} - {2'b00, div_reg};
    assign ge    = ~diff[33];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            num_next  = req.dividend;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[31:0] : trial[31:0];
            num_next = {num_reg[31:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lkci_pkg::*;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    looping_keyframe_colour_interpolator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the block's registers and animation state.
    logic [31:0] period_reg = '0;
    logic [63:0] key_times_reg = KEY_TIMES_RESET;
    logic [31:0] key_colour_reg [4] = '{COLOUR_WHITE, COLOUR_WHITE, COLOUR_WHITE, COLOUR_WHITE};
    logic [31:0] phase_acc = '0;
    logic        started = 1'b0;
    logic [31:0] colour_now = COLOUR_WHITE;

    logic [31:0] tick_queue [$];
    rgba_t       colour_queue [$];
    int          failures = 0;
    bit          tick_taken = 1'b0;
    bit          idle_enabled = 1'b1;
    bit          hold_request = 1'b0;
    int          hold_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit idle_roll();
        return idle_enabled && ($urandom_range(99) < 19);
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [63:0] val);
        case (idx)
            CFG_LOOP_PERIOD:  period_reg = val[31:0];
            CFG_KEY_TIMES:    key_times_reg = val;
            CFG_KEY_COLOUR_0: key_colour_reg[0] = val[31:0];
            CFG_KEY_COLOUR_1: key_colour_reg[1] = val[31:0];
            CFG_KEY_COLOUR_2: key_colour_reg[2] = val[31:0];
            CFG_KEY_COLOUR_3: key_colour_reg[3] = val[31:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] mix_colours(logic [31:0] from, logic [31:0] to,
                                                logic [31:0] w);
        logic [31:0] res;
        logic [31:0] ch;
        res = '0;
        for (int s = 0; s < 4; s++) begin
            ch = ({24'd0, to[8*s +: 8]} * w + {24'd0, from[8*s +: 8]} * (32'd32768 - w)
                  + 32'd16384) >> 15;
            res[8*s +: 8] = ch[7:0];
        end
        return res;
    endfunction

    // Advances the loop phase by one tick and returns the colour shown afterwards.
    function automatic rgba_t advance_colour(logic [31:0] delta);
        logic [32:0] sum;
        logic [46:0] scaled;
        logic [46:0] frac_wide;
        logic [31:0] frac;
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] w;
        bit          found;
        rgba_t       res;
        if (delta != 0) begin
            started = 1'b1;
        end
        if (period_reg != 0) begin
            sum = {1'b0, phase_acc} + {1'b0, delta};
            sum = sum % {1'b0, period_reg};
            phase_acc = sum[31:0];
        end
        if (period_reg != 0 && started) begin
            scaled = {phase_acc, 15'd0};
            frac_wide = scaled / {15'd0, period_reg};
            frac = frac_wide[31:0];
            if (frac <= {16'd0, key_times_reg[15:0]}) begin
                colour_now = key_colour_reg[0];
            end else if (frac >= {16'd0, key_times_reg[63:48]}) begin
                colour_now = key_colour_reg[3];
            end else begin
                found = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    k0 = {16'd0, key_times_reg[16*i +: 16]};
                    k1 = {16'd0, key_times_reg[16*(i+1) +: 16]};
                    if (!found && frac >= k0 && frac < k1) begin
                        found = 1'b1;
                        w = ((frac - k0) << 15) / (k1 - k0);
                        colour_now = mix_colours(key_colour_reg[i], key_colour_reg[i+1], w);
                    end
                end
            end
        end
        res.red   = colour_now[31:24];
        res.green = colour_now[23:16];
        res.blue  = colour_now[15:8];
        res.alpha = colour_now[7:0];
        return res;
    endfunction

    function automatic void check_channel(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Tick driver.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || tick_taken)) begin
            if (tick_queue.size() != 0 && !idle_roll()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= tick_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Colour receiver, with a long hold-off when requested.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_roll();
        end
    end

    // Monitor: tracks register writes and ticks, checks colour beats.
    always @(posedge aclk) begin
        rgba_t want;
        tick_taken = 1'b0;
        if (aresetn) begin
            tick_taken = s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                apply_register(cfg_index, cfg_data);
            end
            if (tick_taken) begin
                colour_queue.push_back(advance_colour(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (colour_queue.size() == 0) begin
                    $error("colour beat with no tick outstanding: %h", m_tdata);
                    failures++;
                end else begin
                    want = colour_queue.pop_front();
                    check_channel("red",   want.red,   m_tdata[7:0]);
                    check_channel("green", want.green, m_tdata[15:8]);
                    check_channel("blue",  want.blue,  m_tdata[23:16]);
                    check_channel("alpha", want.alpha, m_tdata[31:24]);
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge aclk); while (tick_queue.size() != 0 || s_tvalid || colour_queue.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_colours(input logic [31:0] c0, input logic [31:0] c1,
                                 input logic [31:0] c2, input logic [31:0] c3);
        write_reg(CFG_KEY_COLOUR_0, {$urandom, c0});
        write_reg(CFG_KEY_COLOUR_1, {$urandom, c1});
        write_reg(CFG_KEY_COLOUR_2, {$urandom, c2});
        write_reg(CFG_KEY_COLOUR_3, {$urandom, c3});
    endtask

    function automatic logic [31:0] pick_tick(logic [31:0] period);
        int r;
        r = $urandom_range(99);
        if (r < 5) begin
            return 32'd0;
        end else if (r < 10) begin
            return 32'hFFFF_FFFF;
        end else if (r < 40 || period == 0) begin
            return $urandom;
        end
        return $urandom_range(period / 8 + 1, 1);
    endfunction

    initial begin
        logic [31:0] period;
        logic [63:0] keys;
        logic [15:0] k [4];

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero period straight after reset: the colour stays white.
        @(posedge aclk);
        tick_queue.push_back(32'd0);
        wait_idle();

        write_reg(CFG_SPARE_LO, 64'h0000_0000_0001_0000);
        write_reg(CFG_SPARE_HI, 64'h1234_5678_9ABC_DEF0);
        write_reg(CFG_LOOP_PERIOD, 64'hDEAD_BEEF_0001_0000);
        write_reg(CFG_KEY_TIMES, 64'h7000_5000_3000_1000);
        write_colours(32'hFF00_0000, 32'h00FF_00FF, 32'h0000_FF00, 32'h8040_20FF);
        @(posedge aclk);
        // No time yet, before the first key, on each key, inside the first and third segments,
        // after the last key, wrap-around and the widest delta.
        tick_queue = '{32'd0, 32'h0800, 32'h1800, 32'h2000, 32'h1FFE, 32'h2, 32'h4000,
                       32'h3FFE, 32'h2, 32'h1FFF, 32'h1, 32'hFFFF_FFFF, 32'd0};
        wait_idle();

        // Zero period with time passing: phase and colour hold.
        write_reg(CFG_LOOP_PERIOD, 64'd0);
        @(posedge aclk);
        tick_queue = '{32'hFFFF_FFFF, 32'd5};
        wait_idle();

        // Widest period with unordered keys and a key time above one.
        write_reg(CFG_LOOP_PERIOD, 64'h0000_0000_FFFF_FFFF);
        write_reg(CFG_KEY_TIMES, 64'hFFFF_2000_6000_0000);
        @(posedge aclk);
        tick_queue = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: period = 32'hFFFF_FFFF;
                1: period = 32'd1;
                6: period = 32'd0;
                default: period = ($urandom_range(3) == 0) ? $urandom
                                                           : $urandom_range(32'h0008_0000, 2);
            endcase
            if (p == 0) begin
                keys = 64'd0;
            end else if (p == 1) begin
                keys = 64'hFFFF_FFFF_FFFF_FFFF;
            end else if ($urandom_range(4) == 0) begin
                keys = {$urandom, $urandom};
            end else begin
                k[0] = 16'($urandom_range(8192));
                for (int i = 1; i < 4; i++) begin
                    k[i] = k[i-1] + 16'($urandom_range(8192));
                end
                keys = {k[3], k[2], k[1], k[0]};
            end
            write_reg(CFG_LOOP_PERIOD, {$urandom, period});
            write_reg(CFG_KEY_TIMES, keys);
            if (p == 0) begin
                write_colours(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
            end else begin
                write_colours($urandom, $urandom, $urandom, $urandom);
            end
            idle_enabled = (p != 2);
            @(posedge aclk);
            if (p == 4) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < 150; n++) begin
                tick_queue.push_back(pick_tick(period));
            end
            wait_idle();
        end

        repeat (100) @(posedge aclk);
        if (failures == 0 && colour_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
